// ===== hdl/rational_arithmetic_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Shared concurrent forms of clocked checks.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// Implication check, disabled during reset.
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check, disabled during reset.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared payload types, operation and error codes.
// ----------------------------------------------------------------------------
package rau_pkg;
  localparam int OPERAND_BITS = 32;
  localparam int MAG_BITS = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;
  localparam logic [2:0] OP_LT  = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] left_numerator;
    logic signed [31:0] left_denominator;
    logic signed [31:0] right_numerator;
    logic signed [31:0] right_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_numerator;
    logic [62:0]        result_denominator;
    logic               compare_true;
    logic [1:0]         error_code;
  } out_item_t;

  // Item classified by the front end: operand signs and magnitudes.
  typedef struct packed {
    logic [2:0]              op;
    logic                    ln_neg;
    logic [OPERAND_BITS-1:0] ln_mag;
    logic                    ld_neg;
    logic [OPERAND_BITS-1:0] ld_mag;
    logic                    rn_neg;
    logic [OPERAND_BITS-1:0] rn_mag;
    logic                    rd_neg;
    logic [OPERAND_BITS-1:0] rd_mag;
  } job_t;

  // Magnitude of a field read as two's complement of OPERAND_BITS bits.
  function automatic logic [OPERAND_BITS-1:0] mag_of(input logic [31:0] raw);
    logic [OPERAND_BITS-1:0] v;
    v = raw[OPERAND_BITS-1:0];
    return v[OPERAND_BITS-1] ? (~v + 1'b1) : v;
  endfunction
endpackage

// ===== hdl/rau_front.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts items, splits operands into sign and magnitude, queues the jobs.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     in_valid,
  output logic     in_ready,
  output job_t     job,
  output logic     job_valid,
  input  logic     job_ready
);
  localparam int DEPTH = 2;
  job_t       q [DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  job_t       fresh;

  always_comb begin
    fresh.op     = in_item.op;
    fresh.ln_neg = in_item.left_numerator[OPERAND_BITS-1];
    fresh.ln_mag = mag_of(in_item.left_numerator);
    fresh.ld_neg = in_item.left_denominator[OPERAND_BITS-1];
    fresh.ld_mag = mag_of(in_item.left_denominator);
    fresh.rn_neg = in_item.right_numerator[OPERAND_BITS-1];
    fresh.rn_mag = mag_of(in_item.right_numerator);
    fresh.rd_neg = in_item.right_denominator[OPERAND_BITS-1];
    fresh.rd_mag = mag_of(in_item.right_denominator);
  end

  assign in_ready  = (count != 2'(DEPTH));
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wr_ptr] <= fresh;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (job_valid && job_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(job_valid && job_ready);
    end
  end
endmodule

// ===== hdl/rau_back.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Reduces operands by a serial GCD, cross-multiplies, reduces arithmetic results too.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_valid,
  output logic      job_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);
  `include "rational_arithmetic_unit_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_GCD_SETUP, S_MOD, S_DIV, S_NEXT, S_CROSS, S_CROSS2, S_FINISH, S_OUT
  } state_t;

  state_t      state;
  job_t        jb;
  // Fraction under reduction and the GCD / quotient datapath.
  logic        f_neg;
  logic [63:0] f_num, f_den;
  logic [63:0] ga, gb;
  logic [63:0] rem, quo, dvd, dvs;
  logic [6:0]  bitc;
  logic [1:0]  dphase;   // 0 mod, 1 numerator quotient, 2 denominator quotient
  logic [1:0]  which;    // 0 left, 1 right, 2 result
  logic        a_neg, b_neg;
  logic [63:0] a_num, a_den, b_num, b_den;
  logic [63:0] p1, p2;
  logic [1:0]  err;
  logic        cmp;
  logic [62:0] sat_num;

  logic [64:0] trial;
  assign trial = {rem[63:0], dvd[63]} - {1'b0, dvs};

  // A numerator magnitude beyond the signed range saturates.
  assign sat_num = f_num[63] ? {63{1'b1}} : f_num[62:0];

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            jb    <= job;
            cmp   <= 1'b0;
            which <= 2'd0;
            f_neg <= job.ln_neg != job.ld_neg;
            f_num <= 64'(job.ln_mag);
            f_den <= 64'(job.ld_mag);
            if (job.op > OP_LT) begin
              err   <= ERR_NONE;
              state <= S_FINISH;
            end else if (job.ld_mag == '0 || job.rd_mag == '0) begin
              err   <= ERR_ZERO_DEN;
              state <= S_FINISH;
            end else begin
              err   <= ERR_NONE;
              state <= S_GCD_SETUP;
            end
          end
        end
        S_GCD_SETUP: begin
          ga <= f_num;
          gb <= f_den;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (gb != 64'd0) begin
            dvd <= ga; dvs <= gb; rem <= '0; bitc <= 7'd64; dphase <= 2'd0;
            state <= S_MOD;
          end else if (ga != 64'd0) begin
            dvd <= f_num; dvs <= ga; rem <= '0; bitc <= 7'd64; dphase <= 2'd1;
            state <= S_MOD;
          end else begin
            state <= S_DIV;
          end
        end
        S_MOD: begin
          // One restoring-division step per cycle.
          dvd <= {dvd[62:0], ~trial[64]};
          rem <= trial[64] ? {rem[62:0], dvd[63]} : trial[63:0];
          bitc <= bitc - 7'd1;
          if (bitc == 7'd1) state <= S_DIV;
        end
        S_DIV: begin
          unique case (dphase)
            2'd0: begin ga <= gb; gb <= rem; state <= S_NEXT; end
            2'd1: begin
              f_num <= dvd;
              dvd <= f_den; dvs <= ga; rem <= '0; bitc <= 7'd64; dphase <= 2'd2;
              state <= S_MOD;
            end
            default: begin
              if (bitc == 7'd0 && dphase == 2'd2) f_den <= dvd;
              state <= S_CROSS;
            end
          endcase
        end
        S_CROSS: begin
          // Normalise the reduced fraction; a zero becomes 0/1.
          if (f_num == 64'd0) begin f_neg <= 1'b0; f_den <= 64'd1; end
          state <= S_CROSS2;
        end
        S_CROSS2: begin
          if (which == 2'd0) begin
            a_neg <= f_neg; a_num <= f_num; a_den <= f_den;
            which <= 2'd1;
            f_neg <= jb.rn_neg != jb.rd_neg;
            f_num <= 64'(jb.rn_mag);
            f_den <= 64'(jb.rd_mag);
            state <= S_GCD_SETUP;
          end else if (which == 2'd1) begin
            b_neg <= f_neg; b_num <= f_num; b_den <= f_den;
            which <= 2'd2;
            p1 <= a_num[OPERAND_BITS-1:0] * f_den[OPERAND_BITS-1:0];
            p2 <= f_num[OPERAND_BITS-1:0] * a_den[OPERAND_BITS-1:0];
            state <= S_CROSS2;
            // Second visit of this state with which == 2 builds the result.
          end else if (which == 2'd2) begin
            which <= 2'd3;
            if (jb.op == OP_DIV && b_num == 64'd0) begin
              err <= ERR_DIV_ZERO;
              state <= S_FINISH;
            end else if (jb.op == OP_EQ) begin
              cmp <= (a_neg == b_neg) && (a_num == b_num) && (a_den == b_den);
              state <= S_FINISH;
            end else if (jb.op == OP_LT) begin
              cmp <= $signed(a_neg ? -p1 : p1) < $signed(b_neg ? -p2 : p2);
              state <= S_FINISH;
            end else begin
              state <= S_GCD_SETUP;
              if (jb.op == OP_MUL) begin
                f_neg <= a_neg != b_neg;
                f_num <= a_num[OPERAND_BITS-1:0] * b_num[OPERAND_BITS-1:0];
                f_den <= a_den[OPERAND_BITS-1:0] * b_den[OPERAND_BITS-1:0];
              end else if (jb.op == OP_DIV) begin
                f_neg <= a_neg != b_neg;
                f_num <= p1;
                f_den <= a_den[OPERAND_BITS-1:0] * b_num[OPERAND_BITS-1:0];
              end else begin
                f_den <= a_den[OPERAND_BITS-1:0] * b_den[OPERAND_BITS-1:0];
                if (a_neg == ((jb.op == OP_SUB) ? ~b_neg : b_neg)) begin
                  f_num <= p1 + p2; f_neg <= a_neg;
                end else if (p1 >= p2) begin
                  f_num <= p1 - p2; f_neg <= a_neg;
                end else begin
                  f_num <= p2 - p1; f_neg <= (jb.op == OP_SUB) ? ~b_neg : b_neg;
                end
              end
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (err != ERR_NONE || which != 2'd3 || jb.op == OP_EQ || jb.op == OP_LT
              || jb.op > OP_LT) begin
            out_item.result_numerator   <= 64'sd0;
            out_item.result_denominator <= 63'd1;
          end else begin
            out_item.result_numerator <= f_neg ? -$signed({1'b0, sat_num})
                                              : $signed({1'b0, sat_num});
            out_item.result_denominator <= f_den[62:0];
          end
          out_item.compare_true <= cmp && (err == ERR_NONE);
          out_item.error_code   <= err;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // After a result reduction, the result pass reaches S_CROSS2 with which 3.
    end
  end

  `RAU_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !job_ready, "back end took a job while busy")
  `RAU_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_item),
                   "result dropped")
  `RAU_ASSERT_IMP(a_den_nonzero, out_valid, out_item.result_denominator != 63'd0, "zero denominator")
endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Latency is data dependent. An error or an undefined op code goes from acceptance through
// S_FINISH to a valid result in S_OUT. Each fraction reduction runs every Euclidean step
// and both quotients through the serial restoring divider.
// Throughput: one item at a time in the back end; the front queue holds two more.
// Reset: synchronous active-high rst empties the queue and idles the back end.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add, subtract, multiply, divide and compare with GCD reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      in_valid,
  output logic      in_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);
  // Classified jobs travel from the front end to the back end through a queue.
  job_t job;
  logic job_valid, job_ready;

  rau_front u_front (
    .clk, .rst, .in_item, .in_valid, .in_ready, .job, .job_valid, .job_ready
  );

  rau_back u_back (
    .clk, .rst, .job, .job_valid, .job_ready, .out_item, .out_valid, .out_ready
  );
endmodule
